@@ rtl/bspl_pkg.sv @@
// Shared types, constants and the basis weight function of the cubic B-spline point core.
// Depends on nothing; every other file of the block imports it.
package bspl_pkg;

    localparam int COORD_W   = 16;
    localparam int SEG_PTS   = 4;
    localparam int WIN_DEPTH = 3;
    localparam int Q_DEPTH   = 2;

    typedef logic signed [COORD_W-1:0] t_coord;

    // One segment: the four control points, index 0 the oldest.
    typedef struct packed {
        logic [SEG_PTS-1:0][COORD_W-1:0] x;
        logic [SEG_PTS-1:0][COORD_W-1:0] y;
    } t_seg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Integer basis weight k of a uniform cubic B-spline at t = j/n, scaled by 6n^3.
    // Only called with constant arguments, at elaboration.
    function automatic int bspl_weight(input int k, input int n, input int j);
        int w;
        case (k)
            0:       w = (n - j) * (n - j) * (n - j);
            1:       w = 4 * n * n * n - 6 * n * j * j + 3 * j * j * j;
            2:       w = n * n * n + 3 * n * n * j + 3 * n * j * j - 3 * j * j * j;
            default: w = j * j * j;
        endcase
        return w;
    endfunction

endpackage

@@ rtl/bspl_front.sv @@
// Front end: takes control point transactions, keeps the three-point window and
// hands each completed segment to the queue. Depends on bspl_pkg.
module bspl_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [15:0]       i_ctrl_x,
    input  logic [15:0]       i_ctrl_y,
    input  logic              i_start_curve,
    input  bspl_pkg::t_q_stat i_q_stat,
    output logic              o_stall,
    output logic              o_push,
    output bspl_pkg::t_seg    o_seg
);
    import bspl_pkg::*;

    logic [1:0]         r_held;
    logic [COORD_W-1:0] r_win_x [WIN_DEPTH];
    logic [COORD_W-1:0] r_win_y [WIN_DEPTH];

    logic       accept;
    logic [1:0] held_eff;
    logic       seg_mode;

    assign o_stall  = i_q_stat.full;
    assign accept   = i_valid && !i_q_stat.full;
    // A start flag drops the held points before this one is taken.
    assign held_eff = i_start_curve ? 2'd0 : r_held;
    assign seg_mode = (held_eff == 2'(WIN_DEPTH));
    assign o_push   = accept && seg_mode;

    assign o_seg.x = {i_ctrl_x, r_win_x[2], r_win_x[1], r_win_x[0]};
    assign o_seg.y = {i_ctrl_y, r_win_y[2], r_win_y[1], r_win_y[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 2'd0;
        end else if (accept && !seg_mode) begin
            r_held <= held_eff + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (!seg_mode) begin
                r_win_x[held_eff] <= i_ctrl_x;
                r_win_y[held_eff] <= i_ctrl_y;
            end else begin
                r_win_x[0] <= r_win_x[1];
                r_win_x[1] <= r_win_x[2];
                r_win_x[2] <= i_ctrl_x;
                r_win_y[0] <= r_win_y[1];
                r_win_y[1] <= r_win_y[2];
                r_win_y[2] <= i_ctrl_y;
            end
        end
    end

endmodule

@@ rtl/bspl_queue.sv @@
// Two-entry segment queue between the front end and the evaluation back end.
// Depends on bspl_pkg.
module bspl_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bspl_pkg::t_seg    i_seg,
    input  logic              i_pop,
    output bspl_pkg::t_seg    o_head,
    output bspl_pkg::t_q_stat o_q_stat
);
    import bspl_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);

    t_seg             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [PTR_W:0]   r_cnt;

    assign o_head         = r_mem[r_rp];
    assign o_q_stat.full  = (r_cnt == (PTR_W+1)'(Q_DEPTH));
    assign o_q_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_seg;
        end
    end

endmodule

@@ rtl/bspl_back.sv @@
// Back end: steps t over each queued segment, weights the four points and divides
// the sums by 6N^3 with a fixed-point reciprocal multiply. Depends on bspl_pkg.
module bspl_back #(
    parameter int STEPS = 20
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bspl_pkg::t_seg    i_seg,
    input  bspl_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [15:0]       o_out_x,
    output logic [15:0]       o_out_y,
    output logic              o_last_of_segment
);
    import bspl_pkg::*;

    localparam int J_W   = $clog2(STEPS + 1);
    localparam int DEN_I = 6 * STEPS * STEPS * STEPS;
    localparam int WT_W  = $clog2(DEN_I + 1);
    localparam int PR_W  = WT_W + COORD_W + 1;
    localparam int SUM_W = PR_W + 2;
    localparam int Q_W   = COORD_W;

    // The weights are non-negative and sum to 6N^3, so a sum magnitude never exceeds
    // 2^15 * 6N^3. With a shift of RS the rounded-up reciprocal is exact over that range.
    localparam int     DEN_W  = $clog2(DEN_I);
    localparam int     MAG_W  = DEN_W + COORD_W - 1;
    localparam int     RS     = 2 * DEN_W + COORD_W - 1;
    localparam longint RM_L   = ((longint'(1) << RS) + longint'(DEN_I) - 1) / longint'(DEN_I);
    localparam int     RM_W   = $clog2(RM_L + 1);
    localparam int     ML_W   = (RM_W + 1) / 2;
    localparam int     MH_W   = RM_W - ML_W;
    localparam int     PROD_W = MAG_W + RM_W + 1;
    localparam logic [ML_W-1:0] RM_LO = ML_W'(RM_L);
    localparam logic [MH_W-1:0] RM_HI = MH_W'(RM_L >> ML_W);

    logic en;
    assign en = !o_valid || !i_stall;

    // Weight table, built from constants at elaboration.
    logic [WT_W-1:0] w_tbl [STEPS+1][SEG_PTS];
    for (genvar g = 0; g <= STEPS; g++) begin : g_row
        for (genvar k = 0; k < SEG_PTS; k++) begin : g_col
            assign w_tbl[g][k] = WT_W'(bspl_weight(k, STEPS, g));
        end
    end

    // Stage 1: step counter and table lookup.
    logic [J_W-1:0]     r_j;
    logic               r1_v;
    logic               r1_last;
    logic [WT_W-1:0]    r1_w  [SEG_PTS];
    logic [COORD_W-1:0] r1_px [SEG_PTS];
    logic [COORD_W-1:0] r1_py [SEG_PTS];
    logic               at_end;

    assign at_end = (r_j == J_W'(STEPS));
    assign o_pop  = en && !i_q_stat.empty && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j  <= '0;
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= !i_q_stat.empty;
            if (!i_q_stat.empty) begin
                r_j <= at_end ? '0 : r_j + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_last <= at_end;
            for (int k = 0; k < SEG_PTS; k++) begin
                r1_w[k]  <= w_tbl[r_j][k];
                r1_px[k] <= i_seg.x[k];
                r1_py[k] <= i_seg.y[k];
            end
        end
    end

    // Stage 2: weight times coordinate.
    logic                    r2_v;
    logic                    r2_last;
    logic signed [PR_W-1:0]  r2_prx [SEG_PTS];
    logic signed [PR_W-1:0]  r2_pry [SEG_PTS];
    logic signed [PR_W-1:0]  m_x    [SEG_PTS];
    logic signed [PR_W-1:0]  m_y    [SEG_PTS];

    always_comb begin
        for (int k = 0; k < SEG_PTS; k++) begin
            m_x[k] = $signed({1'b0, r1_w[k]}) * $signed(r1_px[k]);
            m_y[k] = $signed({1'b0, r1_w[k]}) * $signed(r1_py[k]);
        end
    end

    // Stage 3: pair sums. Stage 4: full sums.
    logic                   r3_v;
    logic                   r3_last;
    logic signed [PR_W:0]   r3_ax [2];
    logic signed [PR_W:0]   r3_ay [2];
    logic                   r4_v;
    logic                   r4_last;
    logic signed [SUM_W-1:0] r4_sx;
    logic signed [SUM_W-1:0] r4_sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_last <= r1_last;
            for (int k = 0; k < SEG_PTS; k++) begin
                r2_prx[k] <= m_x[k];
                r2_pry[k] <= m_y[k];
            end
            r3_last <= r2_last;
            for (int h = 0; h < 2; h++) begin
                r3_ax[h] <= $signed({r2_prx[2*h][PR_W-1], r2_prx[2*h]})
                          + $signed({r2_prx[2*h+1][PR_W-1], r2_prx[2*h+1]});
                r3_ay[h] <= $signed({r2_pry[2*h][PR_W-1], r2_pry[2*h]})
                          + $signed({r2_pry[2*h+1][PR_W-1], r2_pry[2*h+1]});
            end
            r4_last <= r3_last;
            r4_sx   <= $signed({r3_ax[0][PR_W], r3_ax[0]})
                     + $signed({r3_ax[1][PR_W], r3_ax[1]});
            r4_sy   <= $signed({r3_ay[0][PR_W], r3_ay[0]})
                     + $signed({r3_ay[1][PR_W], r3_ay[1]});
        end
    end

    // Stage 5: sign and magnitude. Stage 6: magnitude times the two reciprocal halves.
    // Stage 7: partial products joined and shifted down to the quotient.
    logic [SUM_W-1:0]       abs_x;
    logic [SUM_W-1:0]       abs_y;
    logic                   r5_v;
    logic                   r5_last;
    logic                   r5_nx;
    logic                   r5_ny;
    logic [MAG_W-1:0]       r5_mx;
    logic [MAG_W-1:0]       r5_my;
    logic                   r6_v;
    logic                   r6_last;
    logic                   r6_nx;
    logic                   r6_ny;
    logic [MAG_W+ML_W-1:0]  r6_plx;
    logic [MAG_W+ML_W-1:0]  r6_ply;
    logic [MAG_W+MH_W-1:0]  r6_phx;
    logic [MAG_W+MH_W-1:0]  r6_phy;
    logic [PROD_W-1:0]      prod_x;
    logic [PROD_W-1:0]      prod_y;
    logic                   r7_v;
    logic                   r7_last;
    logic                   r7_nx;
    logic                   r7_ny;
    logic [Q_W-1:0]         r7_qx;
    logic [Q_W-1:0]         r7_qy;

    assign abs_x  = r4_sx[SUM_W-1] ? SUM_W'(0) - r4_sx : r4_sx;
    assign abs_y  = r4_sy[SUM_W-1] ? SUM_W'(0) - r4_sy : r4_sy;
    assign prod_x = {1'b0, r6_phx, {ML_W{1'b0}}} + PROD_W'(r6_plx);
    assign prod_y = {1'b0, r6_phy, {ML_W{1'b0}}} + PROD_W'(r6_ply);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
        end else if (en) begin
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_mx   <= abs_x[MAG_W-1:0];
            r5_my   <= abs_y[MAG_W-1:0];
            r5_nx   <= r4_sx[SUM_W-1];
            r5_ny   <= r4_sy[SUM_W-1];
            r5_last <= r4_last;
            r6_plx  <= r5_mx * RM_LO;
            r6_ply  <= r5_my * RM_LO;
            r6_phx  <= r5_mx * RM_HI;
            r6_phy  <= r5_my * RM_HI;
            r6_nx   <= r5_nx;
            r6_ny   <= r5_ny;
            r6_last <= r5_last;
            r7_qx   <= prod_x[RS +: Q_W];
            r7_qy   <= prod_y[RS +: Q_W];
            r7_nx   <= r6_nx;
            r7_ny   <= r6_ny;
            r7_last <= r6_last;
        end
    end

    // Output register: restores the sign, truncating toward zero.
    logic r_out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_out_x           <= r7_nx ? Q_W'(0) - r7_qx : r7_qx;
            o_out_y           <= r7_ny ? Q_W'(0) - r7_qy : r7_qy;
            o_last_of_segment <= r7_last;
        end
    end

    assign o_valid = r_out_v;

endmodule

@@ rtl/cubic_bspline_curve_points_core.sv @@
// Top level of the uniform cubic B-spline curve point core.
// Depends on bspl_pkg, bspl_front, bspl_queue and bspl_back.
//
//   Channel   Direction  Handshake          Payload
//   -------   ---------  -----------------  -------------------------------------------
//   input     in         i_valid / o_stall  i_ctrl_x, i_ctrl_y, i_start_curve
//   output    out        o_valid / i_stall  o_out_x, o_out_y, o_last_of_segment
//
// A control point that only fills the window gives no result.
// A control point that completes a segment yields SEGMENT_STEPS+1 results, one per cycle
// while i_stall is low: the back end's step counter issues one t value per cycle whenever
// its output is not stalled. With an idle back end the first result of a segment passes
// from the queue through the table lookup, multiply, two adder levels, sign stage,
// reciprocal multiply, quotient add and output registers before it is presented.
// Reset is synchronous and active low; it empties the window, the queue and the pipeline.
// o_stall rises only while the two-entry segment queue is full; i_stall freezes the
// whole back-end pipeline, with the result held in the output register.
module cubic_bspline_curve_points_core #(
    parameter int SEGMENT_STEPS = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_ctrl_x,
    input  logic [15:0] i_ctrl_y,
    input  logic        i_start_curve,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_out_x,
    output logic [15:0] o_out_y,
    output logic        o_last_of_segment
);
    import bspl_pkg::*;

    // Front end to queue: one transaction per completed segment.
    t_seg    seg_in;
    t_seg    seg_head;
    t_q_stat q_stat;
    logic    q_push;
    logic    q_pop;

    // The front end owns the control point window and decides, per transaction,
    // whether the point just fills the window or completes a segment.
    bspl_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_ctrl_x     (i_ctrl_x),
        .i_ctrl_y     (i_ctrl_y),
        .i_start_curve(i_start_curve),
        .i_q_stat     (q_stat),
        .o_stall      (o_stall),
        .o_push       (q_push),
        .o_seg        (seg_in)
    );

    // The queue lets the front end take the next points while a segment is evaluated.
    bspl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_seg   (seg_in),
        .i_pop   (q_pop),
        .o_head  (seg_head),
        .o_q_stat(q_stat)
    );

    // The back end pops a segment after issuing its last step.
    bspl_back #(
        .STEPS(SEGMENT_STEPS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_seg            (seg_head),
        .i_q_stat         (q_stat),
        .o_pop            (q_pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_x          (o_out_x),
        .o_out_y          (o_out_y),
        .o_last_of_segment(o_last_of_segment)
    );

    // A segment is never pushed into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_stat.full))
        else $error("segment pushed into a full queue");

    // A segment is never popped from an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_pop && q_stat.empty))
        else $error("segment popped from an empty queue");

    // Reset leaves no result transaction pending.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // Front-end stall follows the queue fill state alone.
    a_stall_is_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == q_stat.full)
        else $error("input stall does not match queue state");

endmodule

@@ verif/tb_cubic_bspline_curve_points_core.sv @@
// Self-checking testbench for cubic_bspline_curve_points_core: directed table, then random curves.
// Depends on bspl_pkg and the core RTL; it predicts every curve point with exact integer math.
`timescale 1ns / 1ps

module tb_cubic_bspline_curve_points_core;

    import bspl_pkg::*;

    // Number of t steps per segment; every full window yields STEPS+1 curve points.
    localparam int STEPS = 20;

    // Cycles without any accepted transaction before the run is declared hung. The longest
    // legal quiet stretch is the receiver hold-off below, so this leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 5000;

    // Cycles to wait after the last expected point, a few times the pipeline latency.
    localparam int DRAIN_CYCLES = 80;

    // Receiver behavior, counted in cycles after reset release. The hold-off starts early
    // enough that the sender is still offering points, so the segment queue fills up and
    // the core must stall its input. The quiet window is a stretch with no stalls at all.
    localparam int HOLD_AT    = 2000;
    localparam int HOLD_LEN   = 400;
    localparam int QUIET_FROM = 5000;
    localparam int QUIET_TO   = 6500;

    // The sender offers without gaps for this range of random points.
    localparam int NO_GAP_FROM = 150;
    localparam int NO_GAP_TO   = 250;

    localparam int N_RANDOM = 360;

    localparam t_coord C_MAX = 16'sh7FFF;
    localparam t_coord C_MIN = t_coord'(16'h8000);

    // How a directed row is checked: against the predictor, as a point that must not give
    // any result, or as a segment whose points all equal one typed value.
    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_SILENT,
        ROW_FLAT
    } t_row_kind;

    typedef struct packed {
        t_coord    x;
        t_coord    y;
        logic      start;
        t_row_kind kind;
        t_coord    flat_x;
        t_coord    flat_y;
    } t_dir_row;

    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   last;
    } t_curve_pt;

    localparam int N_DIR = 25;

    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        // Right after reset the window is empty even without a start flag.
        '{16'sd100,  -16'sd100, 1'b0, ROW_SILENT,  16'sd0, 16'sd0},
        '{16'sd200,  -16'sd200, 1'b0, ROW_SILENT,  16'sd0, 16'sd0},
        '{16'sd300,  -16'sd300, 1'b0, ROW_SILENT,  16'sd0, 16'sd0},
        '{16'sd400,  -16'sd400, 1'b0, ROW_PREDICT, 16'sd0, 16'sd0},
        // Four equal points at the top of the range give a flat segment at that value.
        '{C_MAX,     C_MAX,     1'b1, ROW_SILENT,  16'sd0, 16'sd0},
        '{C_MAX,     C_MAX,     1'b0, ROW_SILENT,  16'sd0, 16'sd0},
        '{C_MAX,     C_MAX,     1'b0, ROW_SILENT,  16'sd0, 16'sd0},
        '{C_MAX,     C_MAX,     1'b0, ROW_FLAT,    C_MAX,  C_MAX},
        // The same at the bottom of the range.
        '{C_MIN,     C_MIN,     1'b1, ROW_SILENT,  16'sd0, 16'sd0},
        '{C_MIN,     C_MIN,     1'b0, ROW_SILENT,  16'sd0, 16'sd0},
        '{C_MIN,     C_MIN,     1'b0, ROW_SILENT,  16'sd0, 16'sd0},
        '{C_MIN,     C_MIN,     1'b0, ROW_FLAT,    C_MIN,  C_MIN},
        // Alternating extremes stress the widest weighted sums.
        '{C_MAX,     C_MIN,     1'b1, ROW_SILENT,  16'sd0, 16'sd0},
        '{C_MIN,     C_MAX,     1'b0, ROW_SILENT,  16'sd0, 16'sd0},
        '{C_MAX,     C_MIN,     1'b0, ROW_SILENT,  16'sd0, 16'sd0},
        '{C_MIN,     C_MAX,     1'b0, ROW_PREDICT, 16'sd0, 16'sd0},
        '{C_MAX,     C_MIN,     1'b0, ROW_PREDICT, 16'sd0, 16'sd0},
        // Restart on a full window, then tiny values whose sums truncate toward zero.
        '{16'sd0,    16'sd0,    1'b1, ROW_SILENT,  16'sd0, 16'sd0},
        '{-16'sd1,   -16'sd1,   1'b0, ROW_SILENT,  16'sd0, 16'sd0},
        '{16'sd1,    16'sd1,    1'b0, ROW_SILENT,  16'sd0, 16'sd0},
        '{-16'sd1,   16'sd1,    1'b0, ROW_PREDICT, 16'sd0, 16'sd0},
        // Restart on a full window, then with one point held, then with two points held.
        '{16'sd5,    16'sd5,    1'b1, ROW_SILENT,  16'sd0, 16'sd0},
        '{16'sd6,    16'sd6,    1'b1, ROW_SILENT,  16'sd0, 16'sd0},
        '{16'sd7,    -16'sd7,   1'b0, ROW_SILENT,  16'sd0, 16'sd0},
        '{16'sd8,    -16'sd8,   1'b1, ROW_SILENT,  16'sd0, 16'sd0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [15:0] i_ctrl_x;
    logic [15:0] i_ctrl_y;
    logic        i_start_curve;
    logic        o_valid;
    logic        i_stall;
    logic [15:0] o_out_x;
    logic [15:0] o_out_y;
    logic        o_last_of_segment;

    // Predictor state: the control point window, oldest first, and its fill level.
    t_coord    win_x [WIN_DEPTH];
    t_coord    win_y [WIN_DEPTH];
    int        win_held;

    // Curve points computed for the point just taken, and all points still awaited.
    t_curve_pt seg_pts [$];
    t_curve_pt curve_q [$];

    int        err_cnt = 0;
    int        idle_cnt = 0;

    cubic_bspline_curve_points_core #(
        .SEGMENT_STEPS(STEPS)
    ) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_ctrl_x          (i_ctrl_x),
        .i_ctrl_y          (i_ctrl_y),
        .i_start_curve     (i_start_curve),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_out_x           (o_out_x),
        .o_out_y           (o_out_y),
        .o_last_of_segment (o_last_of_segment)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Takes one control point into the window. A full window first yields the STEPS+1
    // points of the segment that the new point completes, then drops its oldest point.
    // The blend is exact: the weights sum to 6*N^3 and division truncates toward zero.
    function automatic void predict_curve(input t_coord px, input t_coord py, input logic st);
        longint    n;
        longint    den;
        longint    jj;
        longint    w0;
        longint    w1;
        longint    w2;
        longint    w3;
        longint    sx;
        longint    sy;
        t_curve_pt pt;
        int        j;
        seg_pts.delete();
        if (st) begin
            win_held = 0;
            for (j = 0; j < WIN_DEPTH; j++) begin
                win_x[j] = '0;
                win_y[j] = '0;
            end
        end
        if (win_held < WIN_DEPTH) begin
            win_x[win_held] = px;
            win_y[win_held] = py;
            win_held++;
        end else begin
            n   = STEPS;
            den = 6 * n * n * n;
            for (j = 0; j <= STEPS; j++) begin
                jj = j;
                w0 = (n - jj) * (n - jj) * (n - jj);
                w1 = 4 * n * n * n - 6 * n * jj * jj + 3 * jj * jj * jj;
                w2 = n * n * n + 3 * n * n * jj + 3 * n * jj * jj - 3 * jj * jj * jj;
                w3 = jj * jj * jj;
                sx = w0 * longint'(win_x[0]) + w1 * longint'(win_x[1])
                   + w2 * longint'(win_x[2]) + w3 * longint'(px);
                sy = w0 * longint'(win_y[0]) + w1 * longint'(win_y[1])
                   + w2 * longint'(win_y[2]) + w3 * longint'(py);
                pt.x    = t_coord'(sx / den);
                pt.y    = t_coord'(sy / den);
                pt.last = (j == STEPS);
                seg_pts.insert(seg_pts.size(), pt);
            end
            win_x[0] = win_x[1];
            win_y[0] = win_y[1];
            win_x[1] = win_x[2];
            win_y[1] = win_y[2];
            win_x[2] = px;
            win_y[2] = py;
        end
    endfunction

    function automatic void queue_predicted();
        foreach (seg_pts[k]) begin
            curve_q.insert(curve_q.size(), seg_pts[k]);
        end
    endfunction

    // Coordinates lean on the extremes and on values near zero, but mostly span the range.
    function automatic t_coord rand_coord();
        t_coord c;
        case ($urandom_range(9))
            0:       c = C_MAX;
            1:       c = C_MIN;
            2, 3:    c = t_coord'($urandom_range(64) - 32);
            default: c = t_coord'($urandom);
        endcase
        return c;
    endfunction

    // Offers one control point, after an optional random gap, and returns at the edge
    // where the transaction is taken, with the predicted points in seg_pts.
    task automatic offer_point(input t_coord px, input t_coord py, input logic st,
                               input bit gaps_ok);
        while (gaps_ok && $urandom_range(99) < 10) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_ctrl_x      <= px;
        i_ctrl_y      <= py;
        i_start_curve <= st;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        predict_curve(px, py, st);
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            err_cnt++;
        end
    endtask

    // Result checker: every transaction on the output channel is matched, field by field,
    // with the oldest point still awaited.
    always @(posedge i_clk) begin
        t_curve_pt want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (curve_q.size() == 0) begin
                $display("%0t: unexpected curve point, expected none, %s x=%0d y=%0d last=%0d",
                         $time, "actual", $signed(o_out_x), $signed(o_out_y),
                         o_last_of_segment);
                err_cnt++;
            end else begin
                want = curve_q.pop_front();
                check_field("out_x", int'(want.x), int'($signed(o_out_x)));
                check_field("out_y", int'(want.y), int'($signed(o_out_y)));
                check_field("last_of_segment", int'(want.last), int'(o_last_of_segment));
            end
        end
    end

    // Watchdog: counts cycles in which neither channel completes a transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cnt <= 0;
        end else if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    // Receiver: random stalls about one cycle in ten, one long hold-off that backs the
    // core up into its input, and a long stretch without any stall.
    initial begin : rx_proc
        int cyc;
        int hold;
        cyc     = 0;
        hold    = 0;
        i_stall = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) begin
            @(posedge i_clk);
        end
        forever begin
            cyc++;
            if (cyc == HOLD_AT) begin
                hold = HOLD_LEN;
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                hold--;
            end else if (cyc >= QUIET_FROM && cyc < QUIET_TO) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < 10);
            end
            @(posedge i_clk);
        end
    end

    initial begin : main_seq
        int     r;
        int     k;
        logic   st;
        t_coord rx;
        t_coord ry;
        t_curve_pt pt;

        win_held      = 0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_ctrl_x      = '0;
        i_ctrl_y      = '0;
        i_start_curve = 1'b0;
        for (k = 0; k < WIN_DEPTH; k++) begin
            win_x[k] = '0;
            win_y[k] = '0;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. Silent rows and flat segments carry their expectation in the
        // row itself; the predictor still follows them so that its window stays in step.
        for (r = 0; r < N_DIR; r++) begin
            offer_point(DIR_ROWS[r].x, DIR_ROWS[r].y, DIR_ROWS[r].start, 1'b1);
            case (DIR_ROWS[r].kind)
                ROW_PREDICT: begin
                    queue_predicted();
                end
                ROW_FLAT: begin
                    for (k = 0; k <= STEPS; k++) begin
                        pt.x    = DIR_ROWS[r].flat_x;
                        pt.y    = DIR_ROWS[r].flat_y;
                        pt.last = (k == STEPS);
                        curve_q.insert(curve_q.size(), pt);
                    end
                end
                default: begin
                end
            endcase
        end

        // Random curves. Most points extend a long curve; an occasional start flag cuts a
        // curve short, sometimes before its window is full, which gives broken sequences.
        for (k = 0; k < N_RANDOM; k++) begin
            st = ($urandom_range(99) < 7);
            rx = rand_coord();
            ry = rand_coord();
            offer_point(rx, ry, st, !(k >= NO_GAP_FROM && k < NO_GAP_TO));
            queue_predicted();
        end
        i_valid <= 1'b0;

        // Wait for every awaited point, then let the pipeline run dry so that any extra
        // result still shows up. The watchdog guards both waits.
        while (curve_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
